// ===== hw/rtl/los_pkg.sv =====
package los_pkg;

  // fixed field widths
  localparam int unsigned PosW         = 32;
  localparam int unsigned WorkW        = 64;
  localparam int unsigned CfgW         = 32;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned IndexW       = 6;
  localparam int unsigned MaxLabelsDef = 64;

  // register reset values
  localparam logic [30:0]        SpacingRst = 31'h0001_0000;
  localparam logic signed [31:0] LowerRst   = 32'sh0000_0000;
  localparam logic signed [31:0] UpperRst   = 32'sh7FFF_FFFF;
  localparam logic [15:0]        RoundsRst  = 16'd100;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SPACING = 2'd0,
    REG_LOWER   = 2'd1,
    REG_UPPER   = 2'd2,
    REG_ROUNDS  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [PosW-1:0] position;
    logic                   last_label;
  } in_word_t;

  typedef struct packed {
    logic signed [PosW-1:0] placed_position;
    logic [IndexW-1:0]      label_index;
    logic                   last_result;
    logic                   overcrowded;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic init;
    logic scan_start;
    logic merge_step;
    logic sum_step;
    logic grp_next;
    logic div_start;
    logic edge_calc;
    logic shift_calc;
    logic base_calc;
    logic wr_step;
    logic round_inc;
    logic emit_load;
    logic clear_cnt;
  } los_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_elem;
    logic grp_end;
    logic single;
    logic grp_last;
    logic wr_end;
    logic hit;
    logic rounds_done;
    logic div_done;
    logic out_free;
  } los_sts_t;

endpackage

// ===== hw/rtl/los_div.sv =====
module los_div import los_pkg::*; #(
  parameter int unsigned DenW = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [WorkW-1:0] num_i,
  input  logic [DenW-1:0]         den_i,
  output logic                    done_o,
  output logic signed [WorkW-1:0] quo_o
);

  localparam int unsigned StepW = $clog2(WorkW);
  localparam logic [StepW-1:0] StepLast = StepW'(WorkW - 1);

  logic [WorkW-1:0] q_q, q_d;
  logic [DenW-1:0]  r_q, r_d;
  logic [DenW-1:0]  den_q;
  logic [StepW-1:0] step_q, step_d;
  logic             neg_q;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DenW:0]    trial;
  logic             take;

  // one quotient bit per cycle, restoring
  assign trial = {r_q, q_q[WorkW-1]};
  assign take  = trial >= {1'b0, den_q};

  always_comb begin
    q_d    = q_q;
    r_d    = r_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      q_d    = num_i[WorkW-1] ? (~num_i + WorkW'(1)) : num_i;
      r_d    = '0;
      step_d = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      q_d    = {q_q[WorkW-2:0], take};
      r_d    = take ? DenW'(trial - {1'b0, den_q}) : DenW'(trial);
      step_d = step_q + StepW'(1);
      if (step_q == StepLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    if (start_i) begin
      den_q <= den_i;
      neg_q <= num_i[WorkW-1];
    end
  end

  // truncation toward zero: negate the magnitude quotient
  assign quo_o  = neg_q ? $signed(~q_q + WorkW'(1)) : $signed(q_q);
  assign done_o = done_q;

endmodule

// ===== hw/rtl/los_datapath.sv =====
module los_datapath import los_pkg::*; #(
  parameter int unsigned MaxLabels = MaxLabelsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  in_word_t           in_word_i,
  input  los_cmd_t           cmd_i,
  output los_sts_t           sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_word_t          out_word_o
);

  localparam int unsigned IW = $clog2(MaxLabels);
  localparam int unsigned CW = $clog2(MaxLabels + 1);
  localparam logic [CW-1:0] CntMax = CW'(MaxLabels);
  localparam logic signed [WorkW-1:0] PosMax =
    {{(WorkW-PosW+1){1'b0}}, {(PosW-1){1'b1}}};
  localparam logic signed [WorkW-1:0] PosMin = ~PosMax;

  // configuration
  logic [30:0]        spacing_q;
  logic signed [31:0] lower_q, upper_q;
  logic [15:0]        max_rounds_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q    <= SpacingRst;
      lower_q      <= LowerRst;
      upper_q      <= UpperRst;
      max_rounds_q <= RoundsRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SPACING: spacing_q    <= cfg_data_i[30:0];
        REG_LOWER:   lower_q      <= $signed(cfg_data_i);
        REG_UPPER:   upper_q      <= $signed(cfg_data_i);
        REG_ROUNDS:  max_rounds_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic signed [WorkW-1:0] lo_w, hi_w, dist_w, dist2_w;
  assign lo_w    = {{(WorkW-32){lower_q[31]}}, lower_q};
  assign hi_w    = {{(WorkW-32){upper_q[31]}}, upper_q};
  assign dist_w  = {{(WorkW-31){1'b0}}, spacing_q};
  assign dist2_w = {{(WorkW-32){1'b0}}, spacing_q, 1'b0};

  // control registers
  logic [CW-1:0]  n_q;
  logic [15:0]    rnd_q;
  logic           crowd_q;
  logic           hit_q;
  logic           out_valid_q;

  // working registers
  logic [IW-1:0]           idx_q, s_q, e_q;
  logic [MaxLabels-1:0]    bnd_q;
  logic signed [WorkW-1:0] rd_q, prev_q, sum_q, off_q, acc_q;
  logic signed [WorkW-1:0] mean_q, first_q, last_q, shift_q, base_q;
  out_word_t               out_q;

  // working store, one write and one registered read
  logic signed [WorkW-1:0] mem [MaxLabels];
  logic                    mem_we;
  logic [IW-1:0]           mem_wa;
  logic signed [WorkW-1:0] mem_wd;

  // entry clamp
  logic signed [WorkW-1:0] pos_w, pos_lo, pos_cl;
  assign pos_w  = {{(WorkW-PosW){in_word_i.position[PosW-1]}}, in_word_i.position};
  assign pos_lo = (pos_w < lo_w) ? lo_w : pos_w;
  assign pos_cl = (pos_lo > hi_w) ? hi_w : pos_lo;

  logic not_full;
  assign not_full = n_q != CntMax;

  assign mem_we = (cmd_i.load && not_full) || cmd_i.wr_step;
  assign mem_wa = cmd_i.load ? n_q[IW-1:0] : idx_q;
  assign mem_wd = cmd_i.load ? pos_cl : (base_q + (acc_q >>> 1));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[idx_q];
  end

  // status terms
  logic [IW-1:0]  idx_nx, e_nx;
  logic           last_elem, coll;
  logic [CW-1:0]  grp_cnt;
  logic signed [IW:0]    se_diff;
  logic signed [IW+32:0] off_prod;
  logic signed [WorkW-1:0] quo;
  logic           div_done;

  assign idx_nx    = idx_q + IW'(1);
  assign e_nx      = e_q + IW'(1);
  assign last_elem = CW'(idx_q) == (n_q - CW'(1));
  assign coll      = (rd_q - prev_q) <= dist_w;
  assign grp_cnt   = CW'(e_q) - CW'(s_q) + CW'(1);
  assign se_diff   = $signed({1'b0, s_q}) - $signed({1'b0, e_q});
  assign off_prod  = se_diff * $signed({1'b0, spacing_q});

  los_div #(.DenW(CW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (sum_q),
    .den_i   (grp_cnt),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      rnd_q       <= '0;
      crowd_q     <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load && not_full) n_q <= n_q + CW'(1);
      if (cmd_i.clear_cnt) n_q <= '0;
      if (cmd_i.init) rnd_q <= '0;
      if (cmd_i.round_inc) rnd_q <= rnd_q + 16'd1;
      if (cmd_i.scan_start) hit_q <= 1'b0;
      if (cmd_i.merge_step && idx_q != '0 && bnd_q[idx_q] && coll) hit_q <= 1'b1;
      if (cmd_i.shift_calc && first_q < lo_w && last_q > hi_w) crowd_q <= 1'b1;
      if (cmd_i.emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working datapath
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) bnd_q <= '1;
    if (cmd_i.scan_start) begin
      idx_q <= '0;
      s_q   <= '0;
      sum_q <= '0;
    end
    // merge: clear a group start when the gap collides
    if (cmd_i.merge_step) begin
      prev_q <= rd_q;
      idx_q  <= idx_nx;
      if (idx_q != '0 && bnd_q[idx_q] && coll) bnd_q[idx_q] <= 1'b0;
    end
    // group sum
    if (cmd_i.sum_step) begin
      sum_q <= sum_q + rd_q;
      e_q   <= idx_q;
      idx_q <= idx_nx;
    end
    if (cmd_i.grp_next) begin
      idx_q <= e_nx;
      s_q   <= e_nx;
      sum_q <= '0;
    end
    if (cmd_i.div_start) begin
      off_q <= {{(WorkW-IW-33){off_prod[IW+32]}}, off_prod};
    end
    // new outer members from the mean
    if (cmd_i.edge_calc) begin
      mean_q  <= quo;
      first_q <= quo + (off_q >>> 1);
      last_q  <= quo + ((-off_q) >>> 1);
    end
    // shift back inside the bounds
    if (cmd_i.shift_calc) begin
      if (first_q < lo_w && last_q > hi_w) begin
        shift_q <= '0;
      end else if (first_q < lo_w) begin
        shift_q <= lo_w - first_q;
      end else if (last_q > hi_w) begin
        shift_q <= hi_w - last_q;
      end else begin
        shift_q <= '0;
      end
    end
    if (cmd_i.base_calc) begin
      base_q <= mean_q + shift_q;
      idx_q  <= s_q;
      acc_q  <= off_q;
    end
    if (cmd_i.wr_step) begin
      acc_q <= acc_q + dist2_w;
      idx_q <= idx_nx;
    end
    // result word with saturation
    if (cmd_i.emit_load) begin
      out_q.placed_position <= (rd_q > PosMax) ? PosMax[PosW-1:0] :
                               (rd_q < PosMin) ? PosMin[PosW-1:0] : rd_q[PosW-1:0];
      out_q.label_index     <= {{(IndexW-IW){1'b0}}, idx_q};
      out_q.last_result     <= last_elem;
      out_q.overcrowded     <= crowd_q;
      idx_q                 <= idx_nx;
    end
  end

  assign sts_o.last_elem   = last_elem;
  assign sts_o.grp_end     = last_elem || bnd_q[idx_nx];
  assign sts_o.single      = s_q == e_q;
  assign sts_o.grp_last    = CW'(e_q) == (n_q - CW'(1));
  assign sts_o.wr_end      = idx_q == e_q;
  assign sts_o.hit         = hit_q;
  assign sts_o.rounds_done = rnd_q >= max_rounds_q;
  assign sts_o.div_done    = div_done;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== hw/rtl/los_ctrl.sv =====
module los_ctrl import los_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_fire_i,
  input  logic     in_last_i,
  input  los_sts_t sts_i,
  output los_cmd_t cmd_o,
  output logic     in_ready_o
);

  typedef enum logic [16:0] {
    S_IDLE    = 17'h00001,
    S_INIT    = 17'h00002,
    S_RCHK    = 17'h00004,
    S_M_ADDR  = 17'h00008,
    S_M_DATA  = 17'h00010,
    S_M_END   = 17'h00020,
    S_A_ADDR  = 17'h00040,
    S_A_DATA  = 17'h00080,
    S_A_GRP   = 17'h00100,
    S_A_DIV   = 17'h00200,
    S_A_EDGE  = 17'h00400,
    S_A_SHIFT = 17'h00800,
    S_A_BASE  = 17'h01000,
    S_A_WR    = 17'h02000,
    S_A_NEXT  = 17'h04000,
    S_E_ADDR  = 17'h08000,
    S_E_DATA  = 17'h10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) state_d = S_INIT;
        end
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = S_RCHK;
      end
      S_RCHK: begin
        cmd_o.scan_start = 1'b1;
        state_d = sts_i.rounds_done ? S_E_ADDR : S_M_ADDR;
      end
      // merge pass over neighbor gaps
      S_M_ADDR: state_d = S_M_DATA;
      S_M_DATA: begin
        cmd_o.merge_step = 1'b1;
        state_d = sts_i.last_elem ? S_M_END : S_M_ADDR;
      end
      S_M_END: begin
        cmd_o.scan_start = 1'b1;
        state_d = sts_i.hit ? S_A_ADDR : S_E_ADDR;
      end
      // adjust pass, one group at a time
      S_A_ADDR: state_d = S_A_DATA;
      S_A_DATA: begin
        cmd_o.sum_step = 1'b1;
        state_d = sts_i.grp_end ? S_A_GRP : S_A_ADDR;
      end
      S_A_GRP: begin
        if (sts_i.single) begin
          state_d = S_A_NEXT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_A_DIV;
        end
      end
      S_A_DIV: begin
        if (sts_i.div_done) state_d = S_A_EDGE;
      end
      S_A_EDGE: begin
        cmd_o.edge_calc = 1'b1;
        state_d = S_A_SHIFT;
      end
      S_A_SHIFT: begin
        cmd_o.shift_calc = 1'b1;
        state_d = S_A_BASE;
      end
      S_A_BASE: begin
        cmd_o.base_calc = 1'b1;
        state_d = S_A_WR;
      end
      S_A_WR: begin
        cmd_o.wr_step = 1'b1;
        if (sts_i.wr_end) state_d = S_A_NEXT;
      end
      S_A_NEXT: begin
        if (sts_i.grp_last) begin
          cmd_o.round_inc = 1'b1;
          state_d = S_RCHK;
        end else begin
          cmd_o.grp_next = 1'b1;
          state_d = S_A_ADDR;
        end
      end
      // emit every label in order
      S_E_ADDR: state_d = S_E_DATA;
      S_E_DATA: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (sts_i.last_elem) begin
            cmd_o.clear_cnt = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_E_ADDR;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

// ===== hw/rtl/label_overlap_spreader_top.sv =====
// Label overlap spreader.
// Input channel (in_valid_i/in_ready_o, in_word_i): one sorted Q16.16 label
// position per word, clamped to the bounds and stored; one word per cycle
// while loading. Words beyond MaxLabels are dropped. The word with
// last_label set starts the batch computation.
// Output channel (out_valid_o/out_ready_i, out_word_o): one word per stored
// label, in order, the final one flagged last_result.
// Each round runs a merge scan and an adjust scan with an address and a data
// state per label, plus, for each group of two or more labels, a 64-step
// serial divider for the mean and one write state per member. Emission uses
// an address and a data state per label. Throughput is bounded by the
// divider and the one-write, one-read working store. Configuration is to
// be written (cfg_we_i, cfg_idx_i, cfg_data_i) while idle; the block does
// not check it. Reset restores register defaults, empties the batch and
// clears the sticky overcrowded flag; no store clearing is needed.
// A stalled receiver holds the output register; the block waits and loses
// nothing. The final word may still wait while the next batch loads.
module label_overlap_spreader_top import los_pkg::*; #(
  parameter int unsigned MaxLabels = MaxLabelsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_word_t           in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_word_t          out_word_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  los_cmd_t cmd;
  los_sts_t sts;
  logic     in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  los_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .in_last_i  (in_word_i.last_label),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  los_datapath #(.MaxLabels(MaxLabels)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== hw/rtl/los_check.sv =====
module los_check import los_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_word_t out_word_i
);

  logic [IndexW-1:0] exp_idx_q;
  logic              crowd_seen_q;

  // expected index and sticky flag, tracked from accepted words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q    <= '0;
      crowd_seen_q <= 1'b0;
    end else if (out_valid_i && out_ready_i) begin
      exp_idx_q    <= out_word_i.last_result ? '0 : out_word_i.label_index + IndexW'(1);
      crowd_seen_q <= crowd_seen_q || out_word_i.overcrowded;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_word_i))
    else $error("output word changed while stalled");

  a_idx_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_word_i.label_index == exp_idx_q)
    else $error("label index out of sequence");

  a_crowd_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && crowd_seen_q |-> out_word_i.overcrowded)
    else $error("overcrowded flag dropped");

endmodule

bind label_overlap_spreader_top los_check u_los_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_i  (out_word_o)
);
